// ===== rtl/pcgbr_pkg.sv =====
// Package for the PCG bounded random generator.
// Holds command codes, register reset values and the XSH-RR output permutation.
// No dependencies.
package pcgbr_pkg;

  localparam logic [1:0] CMD_RESEED  = 2'd0;
  localparam logic [1:0] CMD_BOUNDED = 2'd1;
  localparam logic [1:0] CMD_RAW     = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [0:0] REG_MULTIPLIER = 1'd0;
  localparam logic [0:0] REG_INCREMENT  = 1'd1;

  localparam logic [63:0] MUL_RESET = 64'd6364136223846793005;
  localparam logic [63:0] INC_RESET = 64'd1442695040888963407;

  // XSH-RR: xorshift high bits, then rotate right by the top five bits.
  function automatic logic [31:0] permute(input logic [63:0] s);
    logic [31:0] x;
    logic [4:0]  rot;
    logic [63:0] xx;
    x   = s[58:27] ^ {13'd0, s[63:45]};
    rot = s[63:59];
    xx  = {x, x} >> rot;
    return xx[31:0];
  endfunction

endpackage

// ===== rtl/pcgbr_mul32.sv =====
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// No dependencies.
module pcgbr_mul32 (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

endmodule

// ===== rtl/pcg_bounded_random_generator.sv =====
// Top level of the PCG bounded random generator.
// Depends on pcgbr_pkg and pcgbr_mul32.
//
// Usage:
// Commands enter on the in_ stream: in_tuser carries the command (reseed,
// bounded integer, raw 64-bit fraction), in_tdata the seed and the two bounds.
// Every accepted item gives exactly one 64-bit item on the out_ stream.
// The cfg_ port writes the LCG multiplier (index 0) and increment (index 1)
// in the cycle that cfg_wr_en is high.
// All 64-bit state and range products are built from one 32 x 32 multiplier.
// A state step runs on it through M0 to M3 (three partial products plus the
// increment) and stores the result in POST. The narrow bounded integer adds
// one range product, the raw fraction a second state step, and the wide bounded
// integer a second state step plus three range products (none for the full span).
// in_tready is high only while no item is in work and returns in the cycle
// that out_tvalid rises, so an item is taken only once the last one is done.
// The finished result waits in an output register; a new item is accepted
// while it waits, and its own result is held back until the register drains.
// After reset the block runs a reseed with zero under the reset register
// values, which keeps in_tready low through INIT, M0 to M3 and POST.
module pcg_bounded_random_generator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [191:0]  in_tdata,   // seed_value[63:0], bound_a[127:64], bound_b[191:128]
  input  logic [1:0]    in_tuser,   // cmd[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // value[63:0]
  input  logic          cfg_wr_en,
  input  logic [0:0]    cfg_addr,
  input  logic [63:0]   cfg_wr_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_RNG  = 4'd2;
  localparam logic [3:0] ST_M0   = 4'd3;
  localparam logic [3:0] ST_M1   = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_M3   = 4'd6;
  localparam logic [3:0] ST_POST = 4'd7;
  localparam logic [3:0] ST_P0   = 4'd8;
  localparam logic [3:0] ST_P1   = 4'd9;
  localparam logic [3:0] ST_P2   = 4'd10;
  localparam logic [3:0] ST_P3   = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  logic [3:0]  state_r;
  logic        init_r;
  logic        adv_r;
  logic [1:0]  cmd_r;
  logic [63:0] mul_r;
  logic [63:0] inc_r;
  logic [63:0] lcg_state_r;
  logic [63:0] src_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [63:0] lo_r;
  logic [63:0] hi_r;
  logic [63:0] n_r;
  logic [31:0] r0_r;
  logic [31:0] r1_r;
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  logic [63:0] mul_use;
  logic [63:0] inc_use;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod_r;
  logic [63:0] add_base;
  logic [63:0] add_term;
  logic        narrow;
  logic        full_span;
  logic        a_le_b;
  logic [63:0] bound_a;
  logic [63:0] bound_b;

  assign bound_a    = in_tdata[127:64];
  assign bound_b    = in_tdata[191:128];
  assign a_le_b     = $signed(bound_a) <= $signed(bound_b);
  assign mul_use    = init_r ? pcgbr_pkg::MUL_RESET : mul_r;
  assign inc_use    = init_r ? pcgbr_pkg::INC_RESET : inc_r;
  assign narrow     = (n_r[63:32] == 32'd0) && (n_r[31:0] != 32'd0)
                      && (n_r[31:0] != 32'hFFFF_FFFF);
  assign full_span  = (n_r == 64'd0);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    unique case (state_r)
      ST_M0: begin
        op_a = src_r[31:0];
        op_b = mul_use[31:0];
      end
      ST_M1: begin
        op_a = src_r[31:0];
        op_b = mul_use[63:32];
      end
      ST_M2: begin
        op_a = src_r[63:32];
        op_b = mul_use[31:0];
      end
      ST_P0: begin
        op_a = narrow ? r0_r : r1_r;
        op_b = n_r[31:0];
      end
      ST_P1: begin
        op_a = r1_r;
        op_b = n_r[63:32];
      end
      ST_P2: begin
        op_a = r0_r;
        op_b = n_r[63:32];
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
    endcase
  end

  pcgbr_mul32 u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_comb begin
    unique case (state_r)
      ST_M1: begin
        add_base = inc_use;
        add_term = prod_r;
      end
      ST_M2, ST_M3: begin
        add_base = acc_r;
        add_term = {prod_r[31:0], 32'd0};
      end
      ST_P1, ST_P3: begin
        add_base = acc_r;
        add_term = {32'd0, prod_r[63:32]};
      end
      ST_P2: begin
        add_base = acc_r;
        add_term = prod_r;
      end
      default: begin
        add_base = acc_r;
        add_term = 64'd0;
      end
    endcase
    acc_nxt = add_base + add_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_r       <= 1'b1;
      adv_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      mul_r        <= pcgbr_pkg::MUL_RESET;
      inc_r        <= pcgbr_pkg::INC_RESET;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          pcgbr_pkg::REG_MULTIPLIER: mul_r <= cfg_wr_data;
          pcgbr_pkg::REG_INCREMENT:  inc_r <= cfg_wr_data;
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tuser;
            adv_r <= 1'b0;
            r0_r  <= pcgbr_pkg::permute(lcg_state_r);
            lo_r  <= a_le_b ? bound_a : bound_b;
            hi_r  <= a_le_b ? bound_b : bound_a;
            unique case (in_tuser)
              pcgbr_pkg::CMD_RESEED: begin
                src_r   <= in_tdata[63:0] + inc_r;
                state_r <= ST_M0;
              end
              pcgbr_pkg::CMD_BOUNDED: begin
                src_r   <= lcg_state_r;
                state_r <= ST_RNG;
              end
              pcgbr_pkg::CMD_RAW: begin
                src_r   <= lcg_state_r;
                state_r <= ST_M0;
              end
              default: begin
                acc_r   <= 64'd0;
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_INIT: begin
          src_r   <= pcgbr_pkg::INC_RESET;
          state_r <= ST_M0;
        end
        ST_RNG: begin
          n_r     <= hi_r - lo_r + 64'd1;
          state_r <= ST_M0;
        end
        ST_M0: state_r <= ST_M1;
        ST_M1: begin
          acc_r   <= acc_nxt;
          state_r <= ST_M2;
        end
        ST_M2: begin
          acc_r   <= acc_nxt;
          state_r <= ST_M3;
        end
        ST_M3: begin
          acc_r   <= acc_nxt;
          state_r <= ST_POST;
        end
        ST_POST: begin
          if (init_r) begin
            lcg_state_r <= acc_r;
            init_r      <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            unique case (cmd_r)
              pcgbr_pkg::CMD_RESEED: begin
                lcg_state_r <= acc_r;
                acc_r       <= 64'd0;
                state_r     <= ST_FIN;
              end
              pcgbr_pkg::CMD_BOUNDED: begin
                if (narrow) begin
                  lcg_state_r <= acc_r;
                  state_r     <= ST_P0;
                end else if (!adv_r) begin
                  r1_r    <= pcgbr_pkg::permute(acc_r);
                  src_r   <= acc_r;
                  adv_r   <= 1'b1;
                  state_r <= ST_M0;
                end else begin
                  lcg_state_r <= acc_r;
                  if (full_span) begin
                    acc_r   <= {r1_r, r0_r};
                    state_r <= ST_FIN;
                  end else begin
                    state_r <= ST_P0;
                  end
                end
              end
              pcgbr_pkg::CMD_RAW: begin
                if (!adv_r) begin
                  r1_r    <= pcgbr_pkg::permute(acc_r);
                  src_r   <= acc_r;
                  adv_r   <= 1'b1;
                  state_r <= ST_M0;
                end else begin
                  lcg_state_r <= acc_r;
                  acc_r       <= {r1_r, r0_r};
                  state_r     <= ST_FIN;
                end
              end
              default: state_r <= ST_FIN;
            endcase
          end
        end
        ST_P0: begin
          acc_r   <= lo_r;
          state_r <= narrow ? ST_P3 : ST_P1;
        end
        ST_P1: begin
          acc_r   <= acc_nxt;
          state_r <= ST_P2;
        end
        ST_P2: begin
          acc_r   <= acc_nxt;
          state_r <= ST_P3;
        end
        ST_P3: begin
          acc_r   <= acc_nxt;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= acc_r;
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pcgbr_checker.sv =====
// Port-level checker for the PCG bounded random generator, bound to the top level.
// Depends on pcg_bounded_random_generator.
module pcgbr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata
);

  // A stalled result item keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  // The block is busy in the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // A new result appears exactly when the block turns idle again.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result presented while still busy");

  // Reset empties the output and starts the seeding pass.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("reset did not clear the channels");

endmodule

bind pcg_bounded_random_generator pcgbr_checker u_pcgbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
